/* hw/rtl/ltws_pkg.sv */
// ----------------------------------------------------------------------------
// ltws_pkg
// Types and constants shared by the lossy token weighted sum core.
// ----------------------------------------------------------------------------
package ltws_pkg;

  localparam int VALUE_W     = 32;  // Q16.16 token and sum values
  localparam int WEIGHT_W    = 16;  // Q4.12 weights
  localparam int SUM_W       = 48;  // Q32.16 running sums
  localparam int PROD_W      = VALUE_W + WEIGHT_W;
  localparam int FRAC_SHIFT  = 12;  // weight fraction bits
  localparam int TERM_W      = PROD_W - FRAC_SHIFT;
  localparam int NUM_WEIGHTS = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 16'sd4096;
  localparam logic signed [VALUE_W-1:0]  VALUE_MAX    = 32'sh7fff_ffff;
  localparam logic signed [VALUE_W-1:0]  VALUE_MIN    = 32'sh8000_0000;
  localparam logic signed [SUM_W-1:0]    SUM_MAX      = 48'sh7fff_ffff_ffff;
  localparam logic signed [SUM_W-1:0]    SUM_MIN      = 48'sh8000_0000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY   = 3'd0,
    CFG_DEFAULT  = 3'd1,
    CFG_WEIGHT_0 = 3'd2,
    CFG_WEIGHT_1 = 3'd3,
    CFG_WEIGHT_2 = 3'd4,
    CFG_WEIGHT_3 = 3'd5
  } cfg_reg_e;

  // replacement policy for a lost token
  typedef enum logic [1:0] {
    POLICY_FIXED   = 2'd0,
    POLICY_LAST    = 2'd1,
    POLICY_AVERAGE = 2'd2
  } policy_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_MUL,
    ST_ACC
  } state_e;

  typedef struct packed {
    logic [1:0]                producer_index;
    logic                      token_present;
    logic signed [VALUE_W-1:0] token_value;
    logic                      first_of_iteration;
    logic signed [VALUE_W-1:0] external_sum;
    logic                      last_of_iteration;
  } token_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      saturated;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

endpackage

/* hw/rtl/ltws_stream_if.sv */
// ----------------------------------------------------------------------------
// ltws_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface ltws_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

/* hw/rtl/ltws_ram.sv */
// ----------------------------------------------------------------------------
// ltws_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module ltws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hw/rtl/ltws_div.sv */
// ----------------------------------------------------------------------------
// ltws_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ltws_div #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // one trial subtraction per step
  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = ~diff[DIVISOR_W];

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIVIDEND_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* hw/rtl/lossy_token_weighted_sum_core.sv */
// ----------------------------------------------------------------------------
// lossy_token_weighted_sum_core
// Weighted sum over lossy producer tokens with per-producer state in a RAM.
// One item at a time: each accepted token passes ST_READ, ST_MUL and ST_ACC
// before the core is ready for the next item; a lost token under running average
// also waits in ST_DIV for the bit-serial divider. The result item is registered
// in ST_ACC of the last token, which waits there while an earlier result is held.
// Reset clears all producer state (per-entry valid bits), the accumulator,
// the iteration count and loads the register reset values; no clearing pass.
// ----------------------------------------------------------------------------
module lossy_token_weighted_sum_core
  import ltws_pkg::*;
#(
  parameter int PRODUCERS  = 4,
  parameter int COUNT_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ltws_stream_if.sink   cfg_i,
  ltws_stream_if.sink   tok_i,
  ltws_stream_if.source res_o
);

  localparam int ADDR_W  = (PRODUCERS > 1) ? $clog2(PRODUCERS) : 1;
  localparam int ENTRY_W = SUM_W + VALUE_W + COUNT_BITS;

  state_e state_q, state_d;

  // configuration registers
  logic [1:0]                 policy_q;
  logic signed [VALUE_W-1:0]  default_q;
  logic signed [WEIGHT_W-1:0] weight_q [NUM_WEIGHTS];

  // item and datapath registers
  token_t                     tok_q, tok_d;
  logic signed [VALUE_W-1:0]  val_q, val_d;
  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic                       sneg_q, sneg_d;
  logic signed [VALUE_W-1:0]  acc_q, acc_d;
  logic                       clip_q, clip_d;
  logic [COUNT_BITS-1:0]      iter_q, iter_d;
  result_t                    res_q, res_d;
  logic                       res_valid_q, res_valid_d;

  // producer state memory
  logic [PRODUCERS-1:0]       valid_q;
  logic                       rd_valid_q;
  logic                       ram_we, ram_re;
  logic [ADDR_W-1:0]          ram_raddr, ram_waddr;
  logic [ENTRY_W-1:0]         ram_wdata, ram_rdata, entry;
  logic signed [SUM_W-1:0]    ent_sum;
  logic signed [VALUE_W-1:0]  ent_last;
  logic [COUNT_BITS-1:0]      ent_lost;
  logic [COUNT_BITS-1:0]      rx_count;

  // divider
  logic                       div_start, div_done;
  logic [SUM_W-1:0]           div_dividend, div_quot;
  logic signed [VALUE_W-1:0]  avg_val;

  // arithmetic
  logic                       tok_accept, in_range_in, in_range;
  logic signed [SUM_W:0]      sum_ext;
  logic signed [SUM_W-1:0]    sum_sat;
  logic signed [TERM_W-1:0]   term;
  logic signed [VALUE_W-1:0]  acc_base;
  logic signed [TERM_W+1:0]   acc_ext;
  logic signed [VALUE_W-1:0]  acc_sat;
  logic                       acc_clip;

  assign tok_accept  = tok_i.valid & tok_i.ready;
  assign in_range_in = (32'(tok_i.payload.producer_index) < PRODUCERS);
  assign in_range    = (32'(tok_q.producer_index) < PRODUCERS);

  // configuration writes, indexes beyond the list are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POLICY_FIXED;
      default_q <= '0;
      for (int k = 0; k < NUM_WEIGHTS; k++) begin
        weight_q[k] <= WEIGHT_RESET;
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        CFG_POLICY:   policy_q    <= cfg_i.payload.data[1:0];
        CFG_DEFAULT:  default_q   <= cfg_i.payload.data[VALUE_W-1:0];
        CFG_WEIGHT_0: weight_q[0] <= cfg_i.payload.data[WEIGHT_W-1:0];
        CFG_WEIGHT_1: weight_q[1] <= cfg_i.payload.data[WEIGHT_W-1:0];
        CFG_WEIGHT_2: weight_q[2] <= cfg_i.payload.data[WEIGHT_W-1:0];
        CFG_WEIGHT_3: weight_q[3] <= cfg_i.payload.data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // producer state ram: {running sum, last value, lost count}
  assign ram_raddr = ADDR_W'(tok_i.payload.producer_index);
  assign ram_waddr = ADDR_W'(tok_q.producer_index);
  assign ram_re    = tok_accept & in_range_in;

  ltws_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PRODUCERS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
      end
    end
  end

  assign entry    = rd_valid_q ? ram_rdata : '0;
  assign ent_sum  = entry[ENTRY_W-1 -: SUM_W];
  assign ent_last = entry[COUNT_BITS+VALUE_W-1 -: VALUE_W];
  assign ent_lost = entry[COUNT_BITS-1:0];
  assign rx_count = iter_q - ent_lost;

  // saturating running sum update
  assign sum_ext = (SUM_W+1)'(ent_sum) + (SUM_W+1)'(tok_q.token_value);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // running average: magnitude divided by received count
  assign div_dividend = ent_sum[SUM_W-1] ? SUM_W'(-ent_sum) : SUM_W'(ent_sum);

  ltws_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (rx_count),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // restore sign and clamp quotient to 32 bits
  always_comb begin
    if (!sneg_q) begin
      avg_val = (|div_quot[SUM_W-1:VALUE_W-1]) ? VALUE_MAX : div_quot[VALUE_W-1:0];
    end else if ((|div_quot[SUM_W-1:VALUE_W]) ||
                 (div_quot[VALUE_W-1] && (|div_quot[VALUE_W-2:0]))) begin
      avg_val = VALUE_MIN;
    end else begin
      avg_val = -div_quot[VALUE_W-1:0];
    end
  end

  // weighted term (floor shift) and saturating accumulate
  assign term     = prod_q[PROD_W-1:FRAC_SHIFT];
  assign acc_base = tok_q.first_of_iteration ? tok_q.external_sum : acc_q;
  assign acc_ext  = (TERM_W+2)'(acc_base) + (TERM_W+2)'(term);

  always_comb begin
    acc_clip = 1'b0;
    acc_sat  = acc_ext[VALUE_W-1:0];
    if (acc_ext > (TERM_W+2)'(VALUE_MAX)) begin
      acc_clip = 1'b1;
      acc_sat  = VALUE_MAX;
    end else if (acc_ext < (TERM_W+2)'(VALUE_MIN)) begin
      acc_clip = 1'b1;
      acc_sat  = VALUE_MIN;
    end
  end

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    tok_d       = tok_q;
    val_d       = val_q;
    prod_d      = prod_q;
    sneg_d      = sneg_q;
    acc_d       = acc_q;
    clip_d      = clip_q;
    iter_d      = iter_q;
    res_d       = res_q;
    res_valid_d = res_valid_q & ~res_o.ready;
    ram_we      = 1'b0;
    ram_wdata   = entry;
    div_start   = 1'b0;
    tok_i.ready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (tok_accept) begin
          tok_d   = tok_i.payload;
          state_d = ST_READ;
        end
      end

      ST_READ: begin
        state_d = ST_MUL;
        if (!in_range) begin
          val_d = '0;
        end else if (tok_q.token_present) begin
          ram_we    = 1'b1;
          ram_wdata = {sum_sat, tok_q.token_value, ent_lost};
          val_d     = tok_q.token_value;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {ent_sum, ent_last, COUNT_BITS'(ent_lost + 1'b1)};
          case (policy_q)
            POLICY_LAST: val_d = ent_last;
            POLICY_AVERAGE: begin
              if (rx_count == '0) begin
                val_d = '0;
              end else begin
                div_start = 1'b1;
                sneg_d    = ent_sum[SUM_W-1];
                state_d   = ST_DIV;
              end
            end
            default: val_d = default_q;
          endcase
        end
      end

      ST_DIV: begin
        if (div_done) begin
          val_d   = avg_val;
          state_d = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_d  = val_q * weight_q[tok_q.producer_index];
        state_d = ST_ACC;
      end

      ST_ACC: begin
        // a last token waits until the result register is free
        if (!tok_q.last_of_iteration || !res_valid_q || res_o.ready) begin
          acc_d   = acc_sat;
          clip_d  = (tok_q.first_of_iteration ? 1'b0 : clip_q) | acc_clip;
          state_d = ST_IDLE;
          if (tok_q.last_of_iteration) begin
            res_d.out_value = acc_sat;
            res_d.saturated = clip_d;
            res_valid_d     = 1'b1;
            iter_d          = iter_q + 1'b1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      clip_q      <= 1'b0;
      iter_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      clip_q      <= clip_d;
      iter_q      <= iter_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tok_q  <= tok_d;
    val_q  <= val_d;
    prod_q <= prod_d;
    sneg_q <= sneg_d;
    res_q  <= res_d;
  end

  // result channel
  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

endmodule

/* tb/tb_lossy_token_weighted_sum_core.sv */
// ----------------------------------------------------------------------------
// tb_lossy_token_weighted_sum_core
// Self-checking bench for the lossy token weighted sum core. A directed table
// covers reset values, saturation, every replacement policy and the register
// extremes. Random phases then follow, each with its own register setting.
// Every token is scored by a local model of the per-producer state and the
// Q16.16 accumulator, and the results are compared in order. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_lossy_token_weighted_sum_core
  import ltws_pkg::*;
();

  localparam int          PRODUCERS        = 4;
  localparam int          PHASES           = 8;
  localparam int          ITEMS_PER_PHASE  = 110;
  localparam int          SETTLE_CYCLES    = 64;
  localparam int          LONG_HOLD_AFTER  = 60;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          CYCLE_LIMIT      = 800000;
  localparam logic [1:0]  POLICY_RESERVED  = 2'd3;

  typedef enum logic {ROW_CFG, ROW_TOKEN} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    cfg_reg_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    token_t                tok;
    bit                    typed;
    result_t               res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  ltws_stream_if #(.payload_t(cfg_t))    cfg_if ();
  ltws_stream_if #(.payload_t(token_t))  tok_if ();
  ltws_stream_if #(.payload_t(result_t)) res_if ();

  lossy_token_weighted_sum_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .tok_i  (tok_if),
    .res_o  (res_if)
  );

  // register copies
  logic [1:0]                 pol_q;
  logic signed [VALUE_W-1:0]  dflt_q;
  logic signed [WEIGHT_W-1:0] wgt_q [PRODUCERS];

  // per-producer and iteration state
  longint                     psum  [PRODUCERS];
  logic signed [VALUE_W-1:0]  plast [PRODUCERS];
  logic [31:0]                plost [PRODUCERS];
  logic [31:0]                iter_cnt;
  logic signed [VALUE_W-1:0]  acc_v;
  bit                         clip_v;

  result_t expected_sums [$];
  int      mismatch_cnt;
  int      results_seen;
  int      cycle_cnt;

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // replacement under running average: sum over received count
  function automatic logic signed [VALUE_W-1:0] average_of(input int unsigned i);
    logic [31:0] n;
    longint      q;
    n = iter_cnt - plost[i];
    if (n == 0) return '0;
    q = psum[i] / longint'({32'd0, n});
    if (q > longint'(VALUE_MAX)) return VALUE_MAX;
    if (q < longint'(VALUE_MIN)) return VALUE_MIN;
    return q[VALUE_W-1:0];
  endfunction

  // one token into the weighted sum; returns 1 when it closes the iteration
  function automatic bit weigh_token(input token_t t, output result_t r);
    int unsigned               i;
    logic signed [VALUE_W-1:0] val;
    longint                    s;
    longint                    term;
    longint                    sum;
    r = '0;
    i = 32'(t.producer_index);
    if (t.first_of_iteration) begin
      acc_v  = t.external_sum;
      clip_v = 1'b0;
    end
    if (t.token_present) begin
      s = psum[i] + longint'(t.token_value);
      if (s > longint'(SUM_MAX)) s = longint'(SUM_MAX);
      if (s < longint'(SUM_MIN)) s = longint'(SUM_MIN);
      psum[i]  = s;
      plast[i] = t.token_value;
      val      = t.token_value;
    end else begin
      case (pol_q)
        POLICY_LAST:    val = plast[i];
        POLICY_AVERAGE: val = average_of(i);
        default:        val = dflt_q;
      endcase
      plost[i] = plost[i] + 32'd1;
    end
    // exact product, floor shift back to Q16.16
    term = (longint'(val) * longint'(wgt_q[i])) >>> FRAC_SHIFT;
    sum  = longint'(acc_v) + term;
    if (sum > longint'(VALUE_MAX)) begin
      acc_v  = VALUE_MAX;
      clip_v = 1'b1;
    end else if (sum < longint'(VALUE_MIN)) begin
      acc_v  = VALUE_MIN;
      clip_v = 1'b1;
    end else begin
      acc_v = sum[VALUE_W-1:0];
    end
    if (!t.last_of_iteration) return 1'b0;
    r.out_value = acc_v;
    r.saturated = clip_v;
    iter_cnt    = iter_cnt + 32'd1;
    return 1'b1;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2:       return '0;
      3, 4, 5: return 32'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000;
      6, 7:    return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_weight();
    logic [WEIGHT_W-1:0] w;
    case ($urandom_range(0, 9))
      0:          w = 16'h7fff;
      1:          w = 16'h8000;
      2:          w = '0;
      3, 4, 5, 6: w = 16'($urandom_range(0, 16384)) - 16'd8192;
      default:    w = 16'($urandom);
    endcase
    return {{(CFG_DATA_W-WEIGHT_W){w[WEIGHT_W-1]}}, w};
  endfunction

  function automatic int unsigned pick_gap(input bit burst);
    if (burst) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7, 8:    return $urandom_range(1, 3);
      default:       return $urandom_range(10, 40);
    endcase
  endfunction

  function automatic result_t typed_sum(input logic [VALUE_W-1:0] v, input bit s);
    result_t r;
    r.out_value = v;
    r.saturated = s;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input cfg_reg_e idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row          = '{kind: ROW_CFG, reg_idx: idx, default: '0};
    row.kind     = ROW_CFG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic stim_row_t tok_row(input int idx, input bit present,
                                        input logic [VALUE_W-1:0] value,
                                        input bit first,
                                        input logic [VALUE_W-1:0] ext,
                                        input bit last, input bit typed = 1'b0,
                                        input result_t res = '0);
    stim_row_t row;
    row                        = '{kind: ROW_TOKEN, reg_idx: CFG_POLICY, default: '0};
    row.kind                   = ROW_TOKEN;
    row.reg_idx                = CFG_POLICY;
    row.tok.producer_index     = 2'(idx);
    row.tok.token_present      = present;
    row.tok.token_value        = value;
    row.tok.first_of_iteration = first;
    row.tok.external_sum       = ext;
    row.tok.last_of_iteration  = last;
    row.typed                  = typed;
    row.res                    = res;
    return row;
  endfunction

  // register write; valid stays up when another write follows
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data,
                           input bit more);
    cfg_t c;
    c.index = idx;
    c.data  = data;
    cfg_if.payload <= c;
    cfg_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (!more) cfg_if.valid <= 1'b0;
    case (idx)
      CFG_POLICY:   pol_q = data[1:0];
      CFG_DEFAULT:  dflt_q = data;
      CFG_WEIGHT_0: wgt_q[0] = data[WEIGHT_W-1:0];
      CFG_WEIGHT_1: wgt_q[1] = data[WEIGHT_W-1:0];
      CFG_WEIGHT_2: wgt_q[2] = data[WEIGHT_W-1:0];
      CFG_WEIGHT_3: wgt_q[3] = data[WEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  // offer one item, score it on acceptance, then maybe idle
  task automatic send_token(input token_t t, input bit typed, input result_t typed_res,
                            input bit burst);
    result_t     r;
    int unsigned gap;
    tok_if.payload <= t;
    tok_if.valid   <= 1'b1;
    do @(posedge clk_i); while (!tok_if.ready);
    if (weigh_token(t, r)) expected_sums = {expected_sums, (typed ? typed_res : r)};
    gap = pick_gap(burst);
    if (gap != 0) begin
      tok_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering, let all results come and the core go quiet
  task automatic drain_results();
    tok_if.valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result side ready, with short and long stalls and one long hold-off
  initial begin : drive_res_ready
    int unsigned stall_left;
    int unsigned quiet_left;
    bit          long_hold_done;
    stall_left     = 0;
    quiet_left     = 0;
    long_hold_done = 1'b0;
    res_if.ready   = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && quiet_left == 0) begin
        case ($urandom_range(0, 19))
          0:          quiet_left = $urandom_range(50, 200);
          1:          stall_left = $urandom_range(15, 60);
          2, 3, 4, 5: stall_left = $urandom_range(1, 3);
          default: ;
        endcase
      end
      res_if.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
      if (quiet_left != 0) quiet_left--;
    end
  end

  // compare each result with the oldest expected sum
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result: out_value %h saturated %b",
               res_if.payload.out_value, res_if.payload.saturated);
        mismatch_cnt++;
      end else begin
        want = expected_sums.pop_front();
        if (res_if.payload.out_value !== want.out_value) begin
          $error("out_value: expected %h, got %h", want.out_value,
                 res_if.payload.out_value);
          mismatch_cnt++;
        end
        if (res_if.payload.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated,
                 res_if.payload.saturated);
          mismatch_cnt++;
        end
      end
      results_seen++;
    end
  end

  // run limit
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_lossy_token_weighted_sum_core: FAIL");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   rows [$];
    token_t      t;
    bit          prev_cfg;
    bit          more;
    bit          burst;
    bit          in_order;
    int          phase_items;
    int unsigned n_tok;
    int unsigned start;
    logic [1:0]  pol;
    logic [CFG_DATA_W-1:0] dflt;

    // idle levels and reset state of the model
    rst_ni         = 1'b0;
    tok_if.valid   = 1'b0;
    tok_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    mismatch_cnt   = 0;
    results_seen   = 0;
    pol_q          = POLICY_FIXED;
    dflt_q         = '0;
    for (int i = 0; i < PRODUCERS; i++) begin
      wgt_q[i] = WEIGHT_RESET;
      psum[i]  = 0;
      plast[i] = '0;
      plost[i] = '0;
    end
    iter_cnt = '0;
    acc_v    = '0;
    clip_v   = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    // running average with no token received yet gives zero
    rows = {rows, cfg_row(CFG_POLICY, CFG_DATA_W'(POLICY_AVERAGE))};
    rows = {rows, tok_row(0, 0, 32'h0005_0000, 1, 32'h0003_0000, 1,
                          1, typed_sum(32'h0003_0000, 0))};
    rows = {rows, tok_row(1, 1, 32'h0002_8000, 1, 32'h0000_0000, 0)};
    rows = {rows, tok_row(1, 0, 32'h0000_0000, 0, 32'h0000_0000, 0)};
    rows = {rows, tok_row(2, 1, 32'hfffa_8000, 0, 32'h0000_0000, 0)};
    rows = {rows, tok_row(2, 0, 32'h0000_0000, 0, 32'h0000_0000, 0)};
    rows = {rows, tok_row(3, 0, 32'h0000_0000, 0, 32'h0000_0000, 1)};
    // lost count passing the iteration count wraps the received count
    rows = {rows, tok_row(3, 0, 32'h0000_0000, 1, 32'h0000_1000, 0)};
    rows = {rows, tok_row(3, 0, 32'h0000_0000, 0, 32'h0000_0000, 0)};
    rows = {rows, tok_row(3, 0, 32'h0000_0000, 0, 32'h0000_0000, 1)};
    // initial token as a present zero
    rows = {rows, tok_row(0, 1, 32'h0000_0000, 1, 32'h0000_0000, 1,
                          1, typed_sum(32'h0000_0000, 0))};
    // last seen policy and accumulator clipping both ways
    rows = {rows, cfg_row(CFG_POLICY, CFG_DATA_W'(POLICY_LAST))};
    rows = {rows, tok_row(1, 0, 32'h0000_0000, 1, 32'h0000_0000, 1)};
    rows = {rows, tok_row(2, 1, VALUE_MAX, 1, VALUE_MAX, 1, 1, typed_sum(VALUE_MAX, 1))};
    rows = {rows, tok_row(3, 1, VALUE_MIN, 1, VALUE_MIN, 1, 1, typed_sum(VALUE_MIN, 1))};
    rows = {rows, tok_row(2, 0, 32'h0000_0000, 1, 32'h0000_0000, 1,
                          1, typed_sum(VALUE_MAX, 0))};
    // unused policy code acts as fixed default; weight extremes
    rows = {rows, cfg_row(CFG_POLICY, CFG_DATA_W'(POLICY_RESERVED))};
    rows = {rows, cfg_row(CFG_DEFAULT, VALUE_MAX)};
    rows = {rows, cfg_row(CFG_WEIGHT_0, 32'hffff_8000)};
    rows = {rows, cfg_row(CFG_WEIGHT_1, 32'h0000_7fff)};
    rows = {rows, tok_row(0, 0, 32'h0000_0000, 1, 32'h0000_0000, 1,
                          1, typed_sum(VALUE_MIN, 1))};
    rows = {rows, tok_row(1, 0, 32'h0000_0000, 1, VALUE_MIN, 1, 1, typed_sum(VALUE_MAX, 1))};
    rows = {rows, tok_row(0, 1, 32'h0001_0000, 1, 32'h0000_1000, 1)};
    // clip flag holds to the end of the iteration
    rows = {rows, tok_row(1, 1, VALUE_MAX, 1, 32'h0000_0000, 0)};
    rows = {rows, tok_row(0, 1, VALUE_MAX, 0, 32'h0000_0000, 1)};
    // zero weight, and a restarted iteration with floor rounding
    rows = {rows, cfg_row(CFG_POLICY, CFG_DATA_W'(POLICY_FIXED))};
    rows = {rows, cfg_row(CFG_DEFAULT, VALUE_MIN)};
    rows = {rows, cfg_row(CFG_WEIGHT_2, 32'h0000_0000)};
    rows = {rows, cfg_row(CFG_WEIGHT_3, 32'h0000_7fff)};
    rows = {rows, tok_row(2, 1, VALUE_MIN, 1, 32'h1234_5678, 1,
                          1, typed_sum(32'h1234_5678, 0))};
    rows = {rows, tok_row(3, 0, 32'h0000_0000, 1, 32'h0000_0000, 1,
                          1, typed_sum(VALUE_MIN, 1))};
    rows = {rows, tok_row(0, 1, 32'h0000_0001, 1, VALUE_MAX, 0)};
    rows = {rows, tok_row(1, 1, 32'hffff_ffff, 1, 32'h0000_0000, 1)};

    prev_cfg = 1'b1;
    foreach (rows[n]) begin
      if (rows[n].kind == ROW_CFG) begin
        if (!prev_cfg) drain_results();
        more = (n + 1 < rows.size()) && (rows[n+1].kind == ROW_CFG);
        write_reg(rows[n].reg_idx, rows[n].reg_data, more);
      end else begin
        send_token(rows[n].tok, rows[n].typed, rows[n].res, 1'b0);
      end
      prev_cfg = (rows[n].kind == ROW_CFG);
    end

    // random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      pol  = (p < 4) ? p[1:0] : 2'($urandom_range(0, 3));
      dflt = (p == 0) ? VALUE_MAX : (p == 1) ? VALUE_MIN : rand_value();
      write_reg(CFG_POLICY, CFG_DATA_W'(pol), 1'b1);
      write_reg(CFG_DEFAULT, dflt, 1'b1);
      for (int k = 0; k < PRODUCERS; k++) begin
        write_reg(cfg_reg_e'(int'(CFG_WEIGHT_0) + k),
                  (p == 0) ? 32'h0000_7fff : (p == 1) ? 32'hffff_8000 : rand_weight(),
                  k != PRODUCERS - 1);
      end
      burst       = (p % 3 == 2);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise: a lone token with every field random
          t.producer_index     = 2'($urandom_range(0, 3));
          t.token_present      = 1'($urandom_range(0, 1));
          t.token_value        = rand_value();
          t.first_of_iteration = 1'($urandom_range(0, 1));
          t.external_sum       = rand_value();
          t.last_of_iteration  = 1'($urandom_range(0, 1));
          send_token(t, 1'b0, '0, burst);
          phase_items++;
        end else begin
          // well-formed iteration of one to four producer tokens
          n_tok    = $urandom_range(1, PRODUCERS);
          start    = $urandom_range(0, PRODUCERS - 1);
          in_order = ($urandom_range(0, 9) < 7);
          for (int k = 0; k < n_tok; k++) begin
            t.producer_index     = in_order ? 2'((start + k) % PRODUCERS)
                                            : 2'($urandom_range(0, 3));
            t.token_present      = ($urandom_range(0, 3) != 0);
            t.token_value        = rand_value();
            t.first_of_iteration = (k == 0);
            t.external_sum       = rand_value();
            t.last_of_iteration  = (k == n_tok - 1);
            send_token(t, 1'b0, '0, burst);
          end
          phase_items += n_tok;
        end
      end
    end

    drain_results();
    if (mismatch_cnt == 0) begin
      $display("tb_lossy_token_weighted_sum_core: PASS");
    end else begin
      $display("tb_lossy_token_weighted_sum_core: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ltws_pkg.sv
hw/rtl/ltws_stream_if.sv
hw/rtl/ltws_ram.sv
hw/rtl/ltws_div.sv
hw/rtl/lossy_token_weighted_sum_core.sv
tb/tb_lossy_token_weighted_sum_core.sv
